/* sv/kpr_pkg.sv */
// kpr_pkg: shared constants and types of the key press, repeat and double-click block
// no dependencies; compile first

package kpr_pkg;

    localparam int NUM_ACTIONS_DEF    = 32;
    localparam int NUM_CONDITIONS_DEF = 5;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(0);
    localparam logic [15:0]          WINDOW_RESET = 16'd300;

    typedef struct packed {
        logic               in_range;
        logic               active;
        logic signed [15:0] velocity;
        logic               rep_en;
        logic [15:0]        rep_start;
        logic [15:0]        rep_interval;
        logic [31:0]        now;
    } kpr_item_t;

    typedef struct packed {
        logic               held;
        logic [31:0]        press_stamp;
        logic [31:0]        rel_stamp;
        logic [15:0]        count;
        logic signed [15:0] velocity;
    } kpr_entry_t;

    typedef struct packed {
        logic               pressed;
        logic               released;
        logic               double_click;
        logic               held;
        logic signed [15:0] velocity;
        logic               has_velocity;
    } kpr_result_t;

endpackage

/* sv/kpr_channels.sv */
// kpr_in_if, kpr_out_if: valid/ready channels for key samples and key results
// no dependencies

interface kpr_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         action;
    logic [2:0]         condition;
    logic               active;
    logic signed [15:0] velocity_in;
    logic signed [16:0] repeat_start_ms;
    logic [15:0]        repeat_interval_ms;
    logic [31:0]        now_ms;

    modport source (
        output valid, action, condition, active, velocity_in, repeat_start_ms,
               repeat_interval_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, action, condition, active, velocity_in, repeat_start_ms,
               repeat_interval_ms, now_ms,
        output ready
    );
endinterface

interface kpr_out_if;
    logic               valid;
    logic               ready;
    logic               pressed;
    logic               released;
    logic               double_click;
    logic               held;
    logic signed [15:0] velocity_out;
    logic               has_velocity;

    modport source (
        output valid, pressed, released, double_click, held, velocity_out, has_velocity,
        input  ready
    );
    modport sink (
        input  valid, pressed, released, double_click, held, velocity_out, has_velocity,
        output ready
    );
endinterface

/* sv/kpr_front.sv */
// kpr_front: accepts key samples, checks the slot range and computes the slot index
// depends on kpr_pkg and kpr_in_if

module kpr_front #(
    parameter int NUM_ACTIONS    = kpr_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_CONDITIONS = kpr_pkg::NUM_CONDITIONS_DEF,
    localparam int SLOTS         = NUM_ACTIONS * NUM_CONDITIONS,
    localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    kpr_in_if.sink            in_ch,
    input  logic              clearing,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [SLOT_W-1:0] push_slot,
    output kpr_pkg::kpr_item_t push_item
);
    import kpr_pkg::*;

    logic        in_range;
    logic [31:0] slot_full;

    assign in_range  = (32'(in_ch.action) < NUM_ACTIONS) && (32'(in_ch.condition) < NUM_CONDITIONS);
    assign slot_full = 32'(in_ch.action) * NUM_CONDITIONS + 32'(in_ch.condition);

    assign push_valid  = in_ch.valid && !clearing;
    assign in_ch.ready = push_ready && !clearing;
    assign push_slot   = in_range ? slot_full[SLOT_W-1:0] : '0;

    always_comb
    begin
        push_item.in_range     = in_range;
        push_item.active       = in_ch.active;
        push_item.velocity     = in_ch.velocity_in;
        push_item.rep_en       = !in_ch.repeat_start_ms[16];
        push_item.rep_start    = in_ch.repeat_start_ms[15:0];
        push_item.rep_interval = in_ch.repeat_interval_ms;
        push_item.now          = in_ch.now_ms;
    end

endmodule

/* sv/kpr_queue.sv */
// kpr_queue: short first-in first-out queue between front and back
// depends on kpr_pkg for the default depth

module kpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kpr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    import kpr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/kpr_back.sv */
// kpr_back: per-slot state memory, read-modify-write with forwarding, result register
// depends on kpr_pkg and kpr_out_if

module kpr_back #(
    parameter int SLOTS   = kpr_pkg::NUM_ACTIONS_DEF * kpr_pkg::NUM_CONDITIONS_DEF,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        window,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic [SLOT_W-1:0]  q_slot,
    input  kpr_pkg::kpr_item_t q_item,
    output logic               clearing,
    kpr_out_if.source          out_ch
);
    import kpr_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    kpr_entry_t mem [SLOTS];

    logic              clr_busy_reg, clr_busy_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic              x_valid_reg, x_valid_next;
    logic [SLOT_W-1:0] x_slot_reg;
    kpr_item_t         x_item_reg;
    kpr_entry_t        rd_reg;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [SLOT_W-1:0] fwd_slot_reg;
    kpr_entry_t        fwd_data_reg;
    logic              out_valid_reg, out_valid_next;
    kpr_result_t       out_reg;

    logic              x_go, x_fire, issue, x_write;
    kpr_entry_t        cur, upd;
    kpr_result_t       res;
    logic              edge_press, dclick, rep_fire;
    logic [31:0]       press_stamp, gap, elapsed, product;
    logic [32:0]       limit;
    logic [15:0]       cnt_base, cnt_new;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    kpr_entry_t        wr_data;

    assign x_go     = !out_valid_reg || out_ch.ready;
    assign issue    = q_valid && !clr_busy_reg && (!x_valid_reg || x_go);
    assign q_pop    = issue;
    assign x_fire   = x_valid_reg && x_go;
    assign x_write  = x_fire && x_item_reg.in_range;
    assign clearing = clr_busy_reg;

    // latest written entry for the same slot overrides the registered read
    assign cur = (fwd_valid_reg && fwd_slot_reg == x_slot_reg) ? fwd_data_reg : rd_reg;

    always_comb
    begin
        edge_press  = x_item_reg.active && !cur.held;
        press_stamp = edge_press ? x_item_reg.now : cur.press_stamp;
        cnt_base    = edge_press ? 16'd0 : cur.count;
        gap         = x_item_reg.now - cur.rel_stamp;
        dclick      = edge_press && (gap < {16'd0, window});
        elapsed     = x_item_reg.now - press_stamp;
        product     = {16'd0, x_item_reg.rep_interval} * {16'd0, cnt_base};
        limit       = {1'b0, product} + {17'd0, x_item_reg.rep_start};
        rep_fire    = x_item_reg.active && x_item_reg.rep_en && ({1'b0, elapsed} >= limit);
        cnt_new     = (rep_fire && cnt_base != 16'hFFFF) ? cnt_base + 16'd1 : cnt_base;

        upd.held        = x_item_reg.active;
        upd.press_stamp = x_item_reg.active ? press_stamp : cur.press_stamp;
        upd.rel_stamp   = (!x_item_reg.active && cur.held) ? x_item_reg.now : cur.rel_stamp;
        upd.count       = x_item_reg.active ? cnt_new : cur.count;
        upd.velocity    = x_item_reg.active ? x_item_reg.velocity : cur.velocity;

        if (x_item_reg.in_range)
        begin
            res.pressed      = edge_press || rep_fire;
            res.released     = !x_item_reg.active && cur.held;
            res.double_click = dclick;
            res.held         = upd.held;
            res.velocity     = upd.velocity;
            res.has_velocity = !upd.velocity[15];
        end
        else
        begin
            res = '0;
        end
    end

    always_comb
    begin
        wr_en   = clr_busy_reg || x_write;
        wr_addr = clr_busy_reg ? clr_addr_reg : x_slot_reg;
        wr_data = clr_busy_reg ? kpr_entry_t'('0) : upd;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_SLOT)
            begin
                clr_busy_next = 1'b0;
            end
        end

        x_valid_next   = issue ? 1'b1 : (x_go ? 1'b0 : x_valid_reg);
        out_valid_next = x_go ? x_valid_reg : out_valid_reg;
        fwd_valid_next = fwd_valid_reg || x_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            x_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            x_valid_reg   <= x_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            x_slot_reg <= q_slot;
            x_item_reg <= q_item;
        end
        if (x_write)
        begin
            fwd_slot_reg <= x_slot_reg;
            fwd_data_reg <= upd;
        end
        if (x_fire)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_reg <= mem[q_slot];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pressed      = out_reg.pressed;
    assign out_ch.released     = out_reg.released;
    assign out_ch.double_click = out_reg.double_click;
    assign out_ch.held         = out_reg.held;
    assign out_ch.velocity_out = out_reg.velocity;
    assign out_ch.has_velocity = out_reg.has_velocity;

    a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.pressed && out_reg.released))
        else $error("press and release in one result");

    a_dclick_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.double_click |-> out_reg.pressed)
        else $error("double click without press");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.released |-> !out_reg.held)
        else $error("released slot still held");

    a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !q_pop)
        else $error("item issued during memory clear");

endmodule

/* sv/key_press_repeat_double_click_top.sv */
// channel   dir  modport  payload
// in_ch     in   sink     action, condition, active, velocity_in, repeat timing, now_ms
// out_ch    out  source   pressed, released, double_click, held, velocity_out, has_velocity
// apb       in   -        psel/penable/pwrite/paddr/pwdata, prdata/pready
//
// one key sample per cycle sustained unless out_ch stalls or the slot memory is being cleared
// state lives in one slot memory, read at issue and written back by the execute stage
// after reset the slot memory is cleared slot by slot, in_ch.ready low until it is done
// a stalled out_ch holds the result register and execute stage, then the 4-entry queue fills
//
// top level: instantiates kpr_front, kpr_queue, kpr_back; holds the apb window register
// depends on kpr_pkg, kpr_channels, kpr_front, kpr_queue and kpr_back

module key_press_repeat_double_click_top #(
    parameter int NUM_ACTIONS    = kpr_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_CONDITIONS = kpr_pkg::NUM_CONDITIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kpr_in_if.sink                        in_ch,
    kpr_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kpr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kpr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);
    import kpr_pkg::*;

    localparam int SLOTS  = NUM_ACTIONS * NUM_CONDITIONS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ITEM_W = $bits(kpr_item_t);
    localparam int Q_W    = SLOT_W + ITEM_W;

    logic [15:0]          window_reg, window_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic                 clearing;
    logic                 push_valid, push_ready;
    logic [SLOT_W-1:0]    push_slot;
    kpr_item_t            push_item;
    logic                 q_valid, q_pop;
    logic [Q_W-1:0]       q_data;
    logic [SLOT_W-1:0]    q_slot;
    kpr_item_t            q_item;

    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_WINDOW) ? {16'd0, window_reg} : '0;

    always_comb
    begin
        window_next = window_reg;
        if (cfg_write && reg_idx == REG_WINDOW)
        begin
            window_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    kpr_front #(
        .NUM_ACTIONS    (NUM_ACTIONS),
        .NUM_CONDITIONS (NUM_CONDITIONS)
    ) u_front (
        .in_ch      (in_ch),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_slot  (push_slot),
        .push_item  (push_item)
    );

    kpr_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_slot, push_item}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign q_slot = q_data[Q_W-1:ITEM_W];
    assign q_item = kpr_item_t'(q_data[ITEM_W-1:0]);

    kpr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .window   (window_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_slot   (q_slot),
        .q_item   (q_item),
        .clearing (clearing),
        .out_ch   (out_ch)
    );

endmodule

/* bench/kpr_checker.sv */
// kpr_checker: watches the key sample and key result channels and the apb port,
// predicts each key result from its own slot state and compares it field by field
// depends on kpr_pkg and kpr_channels
`timescale 1ns / 1ps

module kpr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    kpr_in_if                              in_ch,
    kpr_out_if                             out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [kpr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kpr_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             failures,
    output int                             pending,
    output int                             checked,
    output int                             presses,
    output int                             releases,
    output int                             double_clicks
);
    import kpr_pkg::*;

    localparam int          SLOTS     = NUM_ACTIONS_DEF * NUM_CONDITIONS_DEF;
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;
    localparam int          REPORT_MAX = 10;

    logic [15:0]        window;
    logic               held_q  [SLOTS];
    logic [31:0]        press_q [SLOTS];
    logic [31:0]        rel_q   [SLOTS];
    logic [15:0]        count_q [SLOTS];
    logic signed [15:0] vel_q   [SLOTS];
    kpr_result_t        key_results_due[$];
    int fail_n, check_n, press_n, rel_n, dclick_n;

    function automatic kpr_result_t update_key_slot(
        input logic [4:0]         act,
        input logic [2:0]         cond,
        input logic               on,
        input logic signed [15:0] vel,
        input logic signed [16:0] rep_start,
        input logic [15:0]        rep_interval,
        input logic [31:0]        now
    );
        kpr_result_t r;
        int          slot;
        logic [31:0] gap;
        logic [47:0] threshold;
        r = '0;
        if (int'(act) >= NUM_ACTIONS_DEF || int'(cond) >= NUM_CONDITIONS_DEF)
            return r;
        slot = int'(act) * NUM_CONDITIONS_DEF + int'(cond);
        if (on)
        begin
            if (!held_q[slot])
            begin
                r.pressed      = 1'b1;
                press_q[slot]  = now;
                count_q[slot]  = '0;
                gap            = now - rel_q[slot];
                r.double_click = (gap < {16'd0, window});
            end
            held_q[slot] = 1'b1;
            vel_q[slot]  = vel;
            if (!rep_start[16])
            begin
                gap       = now - press_q[slot];
                threshold = 48'(rep_start[15:0]) + 48'(rep_interval) * 48'(count_q[slot]);
                if (48'(gap) >= threshold)
                begin
                    r.pressed = 1'b1;
                    if (count_q[slot] != COUNT_SAT)
                        count_q[slot] = count_q[slot] + 16'd1;
                end
            end
        end
        else
        begin
            if (held_q[slot])
            begin
                r.released  = 1'b1;
                rel_q[slot] = now;
            end
            held_q[slot] = 1'b0;
        end
        r.held         = held_q[slot];
        r.velocity     = vel_q[slot];
        r.has_velocity = !vel_q[slot][15];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kpr_result_t want;
        kpr_result_t got;
        if (!rst_n)
        begin
            window = WINDOW_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                held_q[i]  = 1'b0;
                press_q[i] = '0;
                rel_q[i]   = '0;
                count_q[i] = '0;
                vel_q[i]   = '0;
            end
            key_results_due.delete();
            fail_n = 0; check_n = 0; press_n = 0; rel_n = 0; dclick_n = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[CFG_ADDR_W-1:2] == REG_WINDOW)
                window = pwdata[15:0];

            if (in_ch.valid && in_ch.ready)
            begin
                want = update_key_slot(in_ch.action, in_ch.condition, in_ch.active,
                                       in_ch.velocity_in, in_ch.repeat_start_ms,
                                       in_ch.repeat_interval_ms, in_ch.now_ms);
                press_n  += want.pressed;
                rel_n    += want.released;
                dclick_n += want.double_click;
                key_results_due.push_back(want);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                got.pressed      = out_ch.pressed;
                got.released     = out_ch.released;
                got.double_click = out_ch.double_click;
                got.held         = out_ch.held;
                got.velocity     = out_ch.velocity_out;
                got.has_velocity = out_ch.has_velocity;
                if (key_results_due.size() == 0)
                begin
                    if (fail_n < REPORT_MAX)
                        $display("[%0t] unexpected key result: p=%b r=%b d=%b h=%b v=%h hv=%b",
                                 $time, got.pressed, got.released, got.double_click,
                                 got.held, got.velocity, got.has_velocity);
                    fail_n++;
                end
                else
                begin
                    want = key_results_due.pop_front();
                    check_n++;
                    if (got.pressed !== want.pressed || got.released !== want.released
                        || got.double_click !== want.double_click || got.held !== want.held
                        || got.velocity !== want.velocity
                        || got.has_velocity !== want.has_velocity)
                    begin
                        if (fail_n < REPORT_MAX)
                        begin
                            $display("[%0t] key result mismatch: expected p=%b r=%b d=%b h=%b v=%h hv=%b",
                                     $time, want.pressed, want.released, want.double_click,
                                     want.held, want.velocity, want.has_velocity);
                            $display("[%0t]   actual p=%b r=%b d=%b h=%b v=%h hv=%b",
                                     $time, got.pressed, got.released, got.double_click,
                                     got.held, got.velocity, got.has_velocity);
                        end
                        fail_n++;
                    end
                end
            end
        end
        failures      <= fail_n;
        pending       <= key_results_due.size();
        checked       <= check_n;
        presses       <= press_n;
        releases      <= rel_n;
        double_clicks <= dclick_n;
    end

endmodule

/* bench/testbench.sv */
// testbench: directed and random key samples for key_press_repeat_double_click_top,
// random idling on both channels, window register changes over apb between phases
// depends on kpr_pkg, kpr_channels, the block and kpr_checker
`timescale 1ns / 1ps

module testbench;
    import kpr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SAT_RUN         = 40;
    localparam int POOL_SIZE       = 8;
    localparam int PHASE_ITEMS     = 280;
    localparam logic [16:0] REPEAT_OFF = 17'h1FFFF;
    localparam logic [16:0] REPEAT_MIN = 17'h10000;
    localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'({REG_WINDOW, 2'b00});

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int chk_failures, chk_pending, chk_checked, chk_presses, chk_releases, chk_dclicks;
    int gap_pct;
    int stall_pct;
    int hold_orders;
    int samples_sent;
    int quiet_cycles;
    logic [31:0] clock_ms;
    logic        key_down [POOL_SIZE];

    kpr_in_if  in_ch ();
    kpr_out_if out_ch ();

    key_press_repeat_double_click_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kpr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .failures      (chk_failures),
        .pending       (chk_pending),
        .checked       (chk_checked),
        .presses       (chk_presses),
        .releases      (chk_releases),
        .double_clicks (chk_dclicks)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_sample(input logic [4:0] act, input logic [2:0] cond, input logic on,
                               input logic [15:0] vel, input logic [16:0] rep_start,
                               input logic [15:0] rep_interval, input logic [31:0] now);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.action             <= act;
        in_ch.condition          <= cond;
        in_ch.active             <= on;
        in_ch.velocity_in        <= vel;
        in_ch.repeat_start_ms    <= rep_start;
        in_ch.repeat_interval_ms <= rep_interval;
        in_ch.now_ms             <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly press and release sequences on a small pool of slots with time usually moving forward
    task automatic run_phase(input int items, input int gp, input int sp,
                             input logic [31:0] window_word, input int hold_at,
                             input int drain_at);
        int          k, pick, roll;
        logic [4:0]  act;
        logic [2:0]  cond;
        logic        on;
        logic [15:0] vel;
        logic [16:0] rep_start;
        logic [15:0] rep_interval;
        wait_idle();
        write_reg(WINDOW_ADDR, window_word);
        gap_pct   = gp;
        stall_pct <= sp;
        for (k = 0; k < items; k++)
        begin
            if (k == hold_at)
                hold_orders <= hold_orders + 1;
            if (k == drain_at)
                wait_idle();
            pick = $urandom_range(0, POOL_SIZE - 1);
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                act  = 5'($urandom);
                cond = 3'($urandom_range(5, 7));
                on   = 1'($urandom);
            end
            else if (roll < 16)
            begin
                act  = 5'($urandom);
                cond = 3'($urandom_range(0, 4));
                on   = 1'($urandom);
            end
            else
            begin
                act  = 5'(pick * 4 + 3);
                cond = 3'(pick % 5);
                if ($urandom_range(0, 99) < 30)
                    key_down[pick] = !key_down[pick];
                on = key_down[pick];
            end

            roll = $urandom_range(0, 99);
            if (roll < 85)
                clock_ms = clock_ms + $urandom_range(0, 60);
            else if (roll < 95)
                clock_ms = clock_ms + $urandom_range(0, 2000);
            else if (roll < 98)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = $urandom;

            roll = $urandom_range(0, 99);
            if (roll < 3)
                vel = 16'h8000;
            else if (roll < 6)
                vel = 16'h7FFF;
            else if (roll < 9)
                vel = 16'h0000;
            else
                vel = 16'($urandom);

            roll = $urandom_range(0, 99);
            if (roll < 15)
                rep_start = REPEAT_MIN | 17'($urandom_range(0, 65535));
            else if (roll < 25)
                rep_start = '0;
            else if (roll < 80)
                rep_start = 17'($urandom_range(0, 80));
            else
                rep_start = 17'($urandom_range(0, 65535));

            roll = $urandom_range(0, 99);
            if (roll < 10)
                rep_interval = '0;
            else if (roll < 75)
                rep_interval = 16'($urandom_range(1, 40));
            else
                rep_interval = 16'($urandom_range(0, 65535));

            send_sample(act, cond, on, vel, rep_start, rep_interval, clock_ms);
        end
    endtask

    initial
    begin
        int hold_seen, hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_orders != hold_seen)
            begin
                hold_seen = hold_orders;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [31:0] t0;
        rst_n                    <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.action             <= '0;
        in_ch.condition          <= '0;
        in_ch.active             <= 1'b0;
        in_ch.velocity_in        <= '0;
        in_ch.repeat_start_ms    <= '0;
        in_ch.repeat_interval_ms <= '0;
        in_ch.now_ms             <= '0;
        stall_pct                <= 0;
        hold_orders              <= 0;
        gap_pct      = 0;
        samples_sent = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_down[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // first press after reset lands inside the reset window
        send_sample(5'd0, 3'd0, 1'b1, 16'h0100, REPEAT_OFF, 16'd0, 32'd10);
        send_sample(5'd0, 3'd0, 1'b1, 16'h0200, REPEAT_OFF, 16'd0, 32'd20);
        // velocity kept on release
        send_sample(5'd0, 3'd0, 1'b0, 16'h8000, REPEAT_OFF, 16'd0, 32'd30);
        // gap just below the window, zero start counts as first repeat
        send_sample(5'd0, 3'd0, 1'b1, 16'h0300, 17'd0, 16'd5, 32'd329);
        send_sample(5'd0, 3'd0, 1'b1, 16'h0300, 17'd0, 16'd5, 32'd333);
        send_sample(5'd0, 3'd0, 1'b1, 16'h0300, 17'd0, 16'd5, 32'd334);
        send_sample(5'd0, 3'd0, 1'b1, 16'h0300, 17'd0, 16'd5, 32'd343);
        send_sample(5'd0, 3'd0, 1'b0, 16'h0300, 17'd0, 16'd5, 32'd400);
        // gap equal to the window
        send_sample(5'd0, 3'd0, 1'b1, 16'hFFFF, REPEAT_OFF, 16'd0, 32'd700);
        send_sample(5'd0, 3'd0, 1'b0, 16'h0000, REPEAT_OFF, 16'd0, 32'd710);
        // slots out of range
        send_sample(5'd17, 3'd5, 1'b1, 16'h7FFF, 17'd0, 16'd0, 32'd1000);
        send_sample(5'd5, 3'd6, 1'b0, 16'h1234, 17'd0, 16'd0, 32'd1001);
        send_sample(5'd31, 3'd7, 1'b1, 16'hFFFF, 17'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // largest repeat timing across the timestamp wrap
        send_sample(5'd31, 3'd4, 1'b1, 16'h7FFF, 17'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
        send_sample(5'd31, 3'd4, 1'b1, 16'h8000, 17'hFFFF, 16'hFFFF, 32'h0000_FFEF);
        send_sample(5'd31, 3'd4, 1'b1, 16'h8000, 17'hFFFF, 16'hFFFF,
                    32'hFFFF_FFF0 + 32'd131069);
        send_sample(5'd31, 3'd4, 1'b1, 16'h8000, 17'hFFFF, 16'hFFFF,
                    32'hFFFF_FFF0 + 32'd131070);
        send_sample(5'd31, 3'd4, 1'b0, 16'h0000, REPEAT_MIN, 16'd0, 32'h0003_0000);
        // press at the same time as the release, repeat disabled
        send_sample(5'd31, 3'd4, 1'b1, 16'h0000, REPEAT_MIN, 16'hFFFF, 32'h0003_0000);
        send_sample(5'd31, 3'd4, 1'b1, 16'h0000, REPEAT_MIN, 16'hFFFF, 32'h0004_86A0);
        send_sample(5'd31, 3'd4, 1'b0, 16'h0000, REPEAT_MIN, 16'hFFFF, 32'h0004_86A1);

        // repeat on every millisecond of a long hold, then a huge interval must not repeat
        t0 = 32'd5000;
        send_sample(5'd9, 3'd3, 1'b1, 16'h0040, 17'd0, 16'd1, t0);
        for (int k = 1; k <= SAT_RUN; k++)
            send_sample(5'd9, 3'd3, 1'b1, 16'h0040, 17'd0, 16'd1, t0 + 32'(k));
        send_sample(5'd9, 3'd3, 1'b1, 16'h0040, 17'd0, 16'hFFFF, t0 + 32'(SAT_RUN + 1));
        send_sample(5'd9, 3'd3, 1'b0, 16'h0040, 17'd0, 16'hFFFF, t0 + 32'(SAT_RUN + 2));

        clock_ms = 32'd100000;
        run_phase(PHASE_ITEMS, 0, 0, 32'h0000_FFFF, -1, -1);
        run_phase(PHASE_ITEMS, 49, 0, 32'h0000_0000, -1, -1);
        run_phase(PHASE_ITEMS, 0, 49, $urandom, 60, -1);
        clock_ms = 32'hFFFF_F000;
        run_phase(PHASE_ITEMS, 35, 35, 32'h0000_0001, -1, 100);
        run_phase(PHASE_ITEMS, 49, 49, 32'd300, 150, -1);
        wait_idle();
        repeat (10) @(posedge clk);

        $display("%0d key samples sent, %0d results checked", samples_sent, chk_checked);
        $display("%0d presses, %0d releases, %0d double clicks over five window settings",
                 chk_presses, chk_releases, chk_dclicks);
        if (chk_failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/kpr_pkg.sv
sv/kpr_channels.sv
sv/kpr_front.sv
sv/kpr_queue.sv
sv/kpr_back.sv
sv/key_press_repeat_double_click_top.sv
bench/kpr_checker.sv
bench/testbench.sv
